// ----- src/bsr_pkg.sv -----
// ----------------------------------------------------------------------------
// bsr_pkg: shared types for the byte stream reassembler
// Sequencer states and the command group sent to the slot store.
// ----------------------------------------------------------------------------
`default_nettype none

package bsr_pkg;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_INSERT = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_NONE   = 6'b001000,
    ST_READ   = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_e;

  // Command group from the sequencer to the slot store.
  typedef struct packed {
    logic wr;   // write a byte and mark its slot filled
    logic clr;  // mark a slot empty
  } slot_cmd_t;

endpackage

`default_nettype wire

// ----- src/byte_stream_reassembler_core.sv -----
// ----------------------------------------------------------------------------
// byte_stream_reassembler_core: out-of-order byte stream reassembler
// Stores in-window bytes in a slot ring and drains the contiguous run at
// each segment end, one result beat per byte or a status-only beat if none.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  --------  ---------------------  -----------------------------------------
//  input     start_i && !busy_o     has_byte_i, data_byte_i, byte_index_i,
//                                   segment_first_i, segment_last_i, eof_i,
//                                   output_occupancy_i
//  result    strobe_o (one cycle)   byte_valid_o, out_byte_o, run_last_o,
//                                   stream_ended_o, unassembled_count_o,
//                                   store_empty_o
//
//  An input beat that is not the last of its segment keeps busy_o high only
//  for the insert step (window check and slot write). A last beat also keeps
//  busy_o high through the scan over the fill flags, then through a registered
//  memory read and an emit for each drained byte, or through the NONE state
//  when nothing drains. The single pointer incrementer and the one memory read
//  port pace this sequence; no new input beat is taken until it ends.
//  Reset is asynchronous, active low, and empties every slot at once.
//  The receiver cannot stall: each result beat shows for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_stream_reassembler_core #(
  parameter int CAPACITY = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        has_byte_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [31:0] byte_index_i,
  input  wire logic        segment_first_i,
  input  wire logic        segment_last_i,
  input  wire logic        eof_i,
  input  wire logic [6:0]  output_occupancy_i,
  output logic             strobe_o,
  output logic             byte_valid_o,
  output logic [7:0]       out_byte_o,
  output logic             run_last_o,
  output logic             stream_ended_o,
  output logic [6:0]       unassembled_count_o,
  output logic             store_empty_o
);

  localparam int SW = $clog2(CAPACITY);      // slot address width
  localparam int CW = $clog2(CAPACITY + 1);  // count width, holds CAPACITY
  localparam logic [SW-1:0] LAST_SLOT = SW'(CAPACITY - 1);
  localparam logic [CW-1:0] CAP_C     = CW'(CAPACITY);
  localparam logic [6:0]    CAP_7     = 7'(CAPACITY);
  localparam logic [SW:0]   CAP_S     = (SW + 1)'(CAPACITY);

  bsr_pkg::state_e state_q, state_d;

  // Latched input beat.
  logic        has_q;
  logic [7:0]  data_q;
  logic [31:0] idx_q;
  logic        first_q, last_q, eof_q;
  logic [6:0]  occ_q;

  // Stream state.
  logic [31:0]   next_q, next_d;       // next expected stream index
  logic [SW-1:0] nslot_q, nslot_d;     // next expected index mod CAPACITY
  logic [31:0]   wend_q, wend_d;       // window end
  logic          eseen_q, eseen_d;
  logic [31:0]   epos_q, epos_d;
  logic [CW-1:0] held_q, held_d;
  logic          ended_q, ended_d;

  // Drain sequencer.
  logic [SW-1:0] scan_q, scan_d;       // scan pointer
  logic [CW-1:0] run_q, run_d;         // run length found / bytes left

  // Slot store interface.
  bsr_pkg::slot_cmd_t  cmd;
  logic [SW-1:0]       wr_addr;
  logic [7:0]          rd_data;
  logic [CAPACITY-1:0] filled;

  // Window check datapath.
  logic [6:0]  room;
  logic [31:0] width;
  logic [31:0] gap;
  logic [SW:0] slot_sum;
  logic        in_window;
  logic [31:0] next_plus_run;

  always_comb begin
    room     = (occ_q >= CAP_7) ? 7'd0 : CAP_7 - occ_q;
    width    = first_q ? {25'd0, room} : wend_q - next_q;
    gap      = idx_q - next_q;
    in_window = gap < width;
    // gap stays below CAPACITY inside the window: one compare and subtract.
    slot_sum = {1'b0, nslot_q} + {1'b0, gap[SW-1:0]};
    if (slot_sum >= CAP_S) begin
      slot_sum = slot_sum - CAP_S;
    end
    wr_addr  = slot_sum[SW-1:0];
    next_plus_run = next_q + {{(32 - CW){1'b0}}, run_q};
  end

  function automatic logic [SW-1:0] step_slot(input logic [SW-1:0] s);
    step_slot = (s == LAST_SLOT) ? '0 : s + SW'(1);
  endfunction

  always_comb begin
    state_d = state_q;
    next_d  = next_q;
    nslot_d = nslot_q;
    wend_d  = wend_q;
    eseen_d = eseen_q;
    epos_d  = epos_q;
    held_d  = held_q;
    ended_d = ended_q;
    scan_d  = scan_q;
    run_d   = run_q;
    cmd     = '0;
    case (state_q)
      bsr_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d = bsr_pkg::ST_INSERT;
        end
      end
      bsr_pkg::ST_INSERT: begin
        // Latch the window, then store the byte if it fits an empty slot.
        if (first_q) begin
          wend_d = next_q + {25'd0, room};
        end
        if (has_q && in_window && !filled[wr_addr]) begin
          cmd.wr = 1'b1;
          held_d = held_q + CW'(1);
        end
        if (last_q) begin
          if (eof_q) begin
            eseen_d = 1'b1;
            epos_d  = idx_q + {31'd0, has_q};
          end
          scan_d  = nslot_q;
          run_d   = '0;
          state_d = bsr_pkg::ST_SCAN;
        end else begin
          state_d = bsr_pkg::ST_IDLE;
        end
      end
      bsr_pkg::ST_SCAN: begin
        // Advance over filled slots to size the run before any beat goes out.
        if (run_q < CAP_C && filled[scan_q]) begin
          run_d  = run_q + CW'(1);
          scan_d = step_slot(scan_q);
        end else begin
          held_d  = held_q - run_q;
          ended_d = eseen_q && (next_plus_run == epos_q);
          state_d = (run_q == '0) ? bsr_pkg::ST_NONE : bsr_pkg::ST_READ;
        end
      end
      bsr_pkg::ST_NONE: begin
        state_d = bsr_pkg::ST_IDLE;
      end
      bsr_pkg::ST_READ: begin
        state_d = bsr_pkg::ST_EMIT;
      end
      bsr_pkg::ST_EMIT: begin
        // Drop the slot just delivered and advance the expected index.
        cmd.clr = 1'b1;
        nslot_d = step_slot(nslot_q);
        next_d  = next_q + 32'd1;
        run_d   = run_q - CW'(1);
        state_d = (run_q == CW'(1)) ? bsr_pkg::ST_IDLE : bsr_pkg::ST_READ;
      end
      default: begin
        state_d = bsr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bsr_pkg::ST_IDLE;
      next_q  <= '0;
      nslot_q <= '0;
      wend_q  <= '0;
      eseen_q <= 1'b0;
      epos_q  <= '0;
      held_q  <= '0;
      ended_q <= 1'b0;
      scan_q  <= '0;
      run_q   <= '0;
    end else begin
      state_q <= state_d;
      next_q  <= next_d;
      nslot_q <= nslot_d;
      wend_q  <= wend_d;
      eseen_q <= eseen_d;
      epos_q  <= epos_d;
      held_q  <= held_d;
      ended_q <= ended_d;
      scan_q  <= scan_d;
      run_q   <= run_d;
    end
  end

  // Hold the accepted beat for the insert step.
  always_ff @(posedge clk_i) begin
    if (state_q == bsr_pkg::ST_IDLE && start_i) begin
      has_q   <= has_byte_i;
      data_q  <= data_byte_i;
      idx_q   <= byte_index_i;
      first_q <= segment_first_i;
      last_q  <= segment_last_i;
      eof_q   <= eof_i;
      occ_q   <= output_occupancy_i;
    end
  end

  bsr_slots #(
    .CAPACITY (CAPACITY),
    .SW       (SW)
  ) u_slots (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (data_q),
    .clr_addr_i (nslot_q),
    .rd_addr_i  (nslot_q),
    .rd_data_o  (rd_data),
    .filled_o   (filled)
  );

  // Result beat: drained byte in EMIT, empty marker in NONE.
  assign busy_o              = (state_q != bsr_pkg::ST_IDLE);
  assign strobe_o            = (state_q == bsr_pkg::ST_EMIT) ||
                               (state_q == bsr_pkg::ST_NONE);
  assign byte_valid_o        = (state_q == bsr_pkg::ST_EMIT);
  assign out_byte_o          = (state_q == bsr_pkg::ST_EMIT) ? rd_data : 8'd0;
  assign run_last_o          = (state_q == bsr_pkg::ST_NONE) || (run_q == CW'(1));
  assign stream_ended_o      = ended_q;
  assign unassembled_count_o = 7'(held_q);
  assign store_empty_o       = (held_q == '0);

endmodule

`default_nettype wire

// ----- src/bsr_slots.sv -----
// ----------------------------------------------------------------------------
// bsr_slots: slot ring storage
// Byte memory with one write and one registered read port, plus fill flags.
// ----------------------------------------------------------------------------
`default_nettype none

module bsr_slots #(
  parameter int CAPACITY = 64,
  parameter int SW       = $clog2(CAPACITY)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire bsr_pkg::slot_cmd_t cmd_i,
  input  wire logic [SW-1:0]      wr_addr_i,
  input  wire logic [7:0]         wr_data_i,
  input  wire logic [SW-1:0]      clr_addr_i,
  input  wire logic [SW-1:0]      rd_addr_i,
  output logic [7:0]              rd_data_o,
  output logic [CAPACITY-1:0]     filled_o
);

  logic [7:0]          mem [CAPACITY];
  logic [7:0]          rd_data_q;
  logic [CAPACITY-1:0] filled_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  // Set on write, drop on clear; the two never hit in the same cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= '0;
    end else begin
      if (cmd_i.wr) begin
        filled_q[wr_addr_i] <= 1'b1;
      end
      if (cmd_i.clr) begin
        filled_q[clr_addr_i] <= 1'b0;
      end
    end
  end

  assign rd_data_o = rd_data_q;
  assign filled_o  = filled_q;

endmodule

`default_nettype wire

// ----- dv/reassembly_checker.sv -----
// ----------------------------------------------------------------------------
// reassembly_checker: result predictor and comparator for the reassembler
// Watches the input and result channels, keeps its own copy of the slot ring,
// and checks every result beat against the oldest predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module reassembly_checker #(
  parameter int CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_o,
  input  logic        has_byte_i,
  input  logic [7:0]  data_byte_i,
  input  logic [31:0] byte_index_i,
  input  logic        segment_first_i,
  input  logic        segment_last_i,
  input  logic        eof_i,
  input  logic [6:0]  output_occupancy_i,
  input  logic        strobe_o,
  input  logic        byte_valid_o,
  input  logic [7:0]  out_byte_o,
  input  logic        run_last_o,
  input  logic        stream_ended_o,
  input  logic [6:0]  unassembled_count_o,
  input  logic        store_empty_o,
  output int          fail_count,
  output int          pending,
  output logic [31:0] stream_pos
);

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_ended;
    logic [6:0] unassembled_count;
    logic       store_empty;
  } drained_beat_t;

  logic [7:0]    slot_data [CAPACITY];
  bit            slot_full [CAPACITY];
  logic [31:0]   next_idx;
  logic [31:0]   win_end;
  logic [31:0]   end_pos;
  bit            end_flag;
  int            held;
  int            errors;
  drained_beat_t drained_q [$];

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  // Insert one accepted beat and, at a segment end, queue the drained run.
  task automatic reassemble_beat();
    logic [31:0]   room;
    logic [31:0]   gap;
    logic [31:0]   span;
    int            slot;
    logic [7:0]    run_bytes [$];
    drained_beat_t r;
    if (segment_first_i) begin
      room = (output_occupancy_i >= CAPACITY) ? 32'd0 : 32'(CAPACITY - output_occupancy_i);
      win_end = next_idx + room;
    end
    if (has_byte_i) begin
      gap  = byte_index_i - next_idx;
      span = win_end - next_idx;
      if (gap < span) begin
        slot = int'(byte_index_i % 32'(CAPACITY));
        if (!slot_full[slot]) begin
          slot_full[slot] = 1'b1;
          slot_data[slot] = data_byte_i;
          held++;
        end
      end
    end
    if (!segment_last_i) return;
    if (eof_i) begin
      end_flag = 1'b1;
      end_pos  = byte_index_i + 32'(has_byte_i);
    end
    while (run_bytes.size() < CAPACITY) begin
      slot = int'(next_idx % 32'(CAPACITY));
      if (!slot_full[slot]) break;
      run_bytes.push_back(slot_data[slot]);
      slot_full[slot] = 1'b0;
      held--;
      next_idx++;
    end
    r.stream_ended      = end_flag && (next_idx == end_pos);
    r.unassembled_count = 7'(held);
    r.store_empty       = (held == 0);
    if (run_bytes.size() == 0) begin
      r.byte_valid = 1'b0;
      r.out_byte   = 8'h00;
      r.run_last   = 1'b1;
      drained_q.push_back(r);
    end else begin
      foreach (run_bytes[i]) begin
        r.byte_valid = 1'b1;
        r.out_byte   = run_bytes[i];
        r.run_last   = (i == run_bytes.size() - 1);
        drained_q.push_back(r);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    drained_beat_t want;
    if (!rst_ni) begin
      foreach (slot_full[i]) slot_full[i] = 1'b0;
      next_idx = '0;
      win_end  = '0;
      end_pos  = '0;
      end_flag = 1'b0;
      held     = 0;
      drained_q.delete();
      fail_count <= 0;
      pending    <= 0;
      stream_pos <= '0;
    end else begin
      if (strobe_o) begin
        if (drained_q.size() == 0) begin
          $error("result beat with no prediction waiting");
          errors++;
        end else begin
          want = drained_q.pop_front();
          check_field("byte_valid", want.byte_valid, byte_valid_o);
          check_field("out_byte", want.out_byte, out_byte_o);
          check_field("run_last", want.run_last, run_last_o);
          check_field("stream_ended", want.stream_ended, stream_ended_o);
          check_field("unassembled_count", want.unassembled_count, unassembled_count_o);
          check_field("store_empty", want.store_empty, store_empty_o);
        end
      end
      if (start_i && !busy_o) reassemble_beat();
      fail_count <= errors;
      pending    <= drained_q.size();
      stream_pos <= next_idx;
    end
  end

endmodule

// ----- dv/byte_stream_reassembler_core_tb.sv -----
// ----------------------------------------------------------------------------
// byte_stream_reassembler_core_tb: regression bench for the reassembler core
// Sends directed then random out-of-order segments, at most one byte per beat,
// and lets the side checker predict and compare every drained result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module byte_stream_reassembler_core_tb;

  localparam int CAPACITY     = 64;
  localparam int RANDOM_BEATS = 380;

  logic        clk_i;
  logic        rst_ni              = 1'b0;
  logic        start_i             = 1'b0;
  logic        has_byte_i          = 1'b0;
  logic [7:0]  data_byte_i         = '0;
  logic [31:0] byte_index_i        = '0;
  logic        segment_first_i     = 1'b0;
  logic        segment_last_i      = 1'b0;
  logic        eof_i               = 1'b0;
  logic [6:0]  output_occupancy_i  = '0;
  logic        busy_o;
  logic        strobe_o;
  logic        byte_valid_o;
  logic [7:0]  out_byte_o;
  logic        run_last_o;
  logic        stream_ended_o;
  logic [6:0]  unassembled_count_o;
  logic        store_empty_o;

  int          fail_count;
  int          pending;
  logic [31:0] assembled_pos;   // predicted next expected index, for aiming
  bit          idle_on;         // allow random sender gaps
  int          beats_sent;

  // 8 ns period: low half then high half.
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  byte_stream_reassembler_core #(.CAPACITY(CAPACITY)) DUT (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .has_byte_i, .data_byte_i, .byte_index_i, .segment_first_i,
    .segment_last_i, .eof_i, .output_occupancy_i,
    .strobe_o, .byte_valid_o, .out_byte_o, .run_last_o,
    .stream_ended_o, .unassembled_count_o, .store_empty_o
  );

  reassembly_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .has_byte_i, .data_byte_i, .byte_index_i, .segment_first_i,
    .segment_last_i, .eof_i, .output_occupancy_i,
    .strobe_o, .byte_valid_o, .out_byte_o, .run_last_o,
    .stream_ended_o, .unassembled_count_o, .store_empty_o,
    .fail_count, .pending, .stream_pos(assembled_pos)
  );

  // Drive one beat from a rising edge and hold it until it is accepted.
  // Optionally drop start first so gaps land anywhere, including in the
  // middle of a segment.
  task automatic drive_beat(input logic hb, input logic [7:0] data,
                            input logic [31:0] idx, input logic first,
                            input logic last, input logic eof,
                            input logic [6:0] occ);
    if (idle_on && $urandom_range(0, 99) < 20) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start_i            <= 1'b1;
    has_byte_i         <= hb;
    data_byte_i        <= data;
    byte_index_i       <= idx;
    segment_first_i    <= first;
    segment_last_i     <= last;
    eof_i              <= eof;
    output_occupancy_i <= occ;
    // busy_o read right after the edge is the value the edge sampled.
    do @(posedge clk_i); while (busy_o);
    beats_sent++;
  endtask

  // Drop start at a segment boundary and let the clock advance so the checker's
  // view of the stream position is current before the next segment is aimed.
  task automatic close_segment();
    start_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Send a run of consecutive indices as one segment. Eof is honored only on
  // the last beat, so sprinkle it on earlier beats to show it is ignored.
  task automatic send_segment(input logic [31:0] base, input int len,
                              input logic [6:0] occ, input bit with_first,
                              input bit with_last, input bit eof_mark,
                              input bit empty);
    bit tail;
    for (int k = 0; k < len; k++) begin
      tail = (k == len - 1);
      drive_beat(!empty, 8'($urandom_range(0, 255)), base + 32'(k),
                 with_first && (k == 0), with_last && tail,
                 tail ? eof_mark : ($urandom_range(0, 9) == 0), occ);
    end
    close_segment();
  endtask

  initial begin
    int          pick;
    int          len;
    int          wait_cycles;
    logic [31:0] base;
    logic [6:0]  occ;

    idle_on    = 1'b1;
    beats_sent = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- Directed part -----------------------------------------------------
    // Empty segment: nothing to drain, one status-only result.
    send_segment(32'd0, 1, 7'd0, 1'b1, 1'b1, 1'b0, 1'b1);
    // Out-of-order tail first: stored, still nothing drains.
    drive_beat(1'b1, 8'hA5, 32'd2, 1'b1, 1'b0, 1'b0, 7'd0);
    drive_beat(1'b1, 8'h5A, 32'd3, 1'b0, 1'b1, 1'b0, 7'd0);
    close_segment();
    // Fill the hole: drain four bytes, data extremes included.
    drive_beat(1'b1, 8'h00, 32'd0, 1'b1, 1'b0, 1'b0, 7'd0);
    drive_beat(1'b1, 8'hFF, 32'd1, 1'b0, 1'b1, 1'b0, 7'd0);
    close_segment();
    // Stale index, then a duplicate on an already filled slot: drop both.
    drive_beat(1'b1, 8'h11, 32'd1, 1'b1, 1'b0, 1'b0, 7'd0);
    drive_beat(1'b1, 8'h22, 32'd5, 1'b0, 1'b0, 1'b0, 7'd0);
    drive_beat(1'b1, 8'h33, 32'd5, 1'b0, 1'b1, 1'b0, 7'd0);
    close_segment();
    // Window edge: last slot inside is kept, the first one past it dropped.
    drive_beat(1'b1, 8'h44, 32'd4 + 32'(CAPACITY) - 32'd1, 1'b1, 1'b0, 1'b0, 7'd0);
    drive_beat(1'b1, 8'h55, 32'd4 + 32'(CAPACITY), 1'b0, 1'b1, 1'b0, 7'd0);
    close_segment();
    // Full and over-full occupancy: window closes entirely.
    drive_beat(1'b1, 8'h66, 32'd4, 1'b1, 1'b1, 1'b0, 7'(CAPACITY));
    close_segment();
    drive_beat(1'b1, 8'h77, 32'd4, 1'b1, 1'b0, 1'b1, 7'h7F);
    drive_beat(1'b1, 8'h78, 32'd5, 1'b0, 1'b1, 1'b0, 7'h7F);
    close_segment();
    // Narrow window latched here, then a segment with no first beat reuses it.
    drive_beat(1'b1, 8'h88, 32'd6, 1'b1, 1'b0, 1'b0, 7'(CAPACITY - 4));
    close_segment();
    drive_beat(1'b1, 8'h99, 32'd4, 1'b0, 1'b1, 1'b0, 7'd0);
    close_segment();
    // Eof on a middle beat is ignored, eof on the last beat ends the stream.
    drive_beat(1'b1, 8'hAA, 32'd7, 1'b1, 1'b0, 1'b1, 7'd0);
    drive_beat(1'b1, 8'hBB, 32'd8, 1'b0, 1'b1, 1'b1, 7'd0);
    close_segment();
    // A later empty eof moves the end position out again.
    send_segment(32'd20, 1, 7'd0, 1'b1, 1'b1, 1'b1, 1'b1);
    // Top of the index range: far outside the window.
    drive_beat(1'b1, 8'hCC, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 7'd0);
    close_segment();

    // ---- Random part -------------------------------------------------------
    beats_sent = 0;
    while (beats_sent < RANDOM_BEATS) begin
      // Hold a long stretch with no sender gaps in the middle of the run.
      idle_on = !(beats_sent >= 150 && beats_sent < 260);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // Well-formed segment aimed at or just past the assembly point.
        occ  = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 70))
                                           : 7'($urandom_range(0, 8));
        len  = ($urandom_range(0, 19) == 0) ? $urandom_range(32, CAPACITY)
                                            : $urandom_range(1, 10);
        base = assembled_pos;
        if ($urandom_range(0, 2) != 0) base += 32'($urandom_range(1, 40));
        if ($urandom_range(0, 14) == 0)
          send_segment(base, 1, occ, 1'b1, 1'b1, $urandom_range(0, 11) == 0, 1'b1);
        else
          send_segment(base, len, occ, 1'b1, 1'b1, $urandom_range(0, 11) == 0, 1'b0);
      end else if (pick < 85) begin
        // Noise: every field random across its whole range.
        drive_beat(1'($urandom), 8'($urandom), $urandom, 1'($urandom),
                   1'($urandom), 1'($urandom), 7'($urandom_range(0, 127)));
        close_segment();
      end else begin
        // Broken segment: overlaps stale bytes, or lacks its first or last beat.
        base = assembled_pos - 32'($urandom_range(0, 8));
        send_segment(base, $urandom_range(1, 12), 7'($urandom_range(0, 10)),
                     1'($urandom), 1'($urandom), 1'($urandom), 1'b0);
      end
    end
    // Finish on a clean segment so the last beat drains something.
    send_segment(assembled_pos, 4, 7'd0, 1'b1, 1'b1, 1'b1, 1'b0);

    // ---- Drain and verdict -------------------------------------------------
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 20000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    // Allow for a full drain of the ring.
    repeat (3 * CAPACITY + 8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Runaway guard, far above the slowest legal run.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
